[hdl/psbl_pkg.sv]
`default_nettype none

package psbl_pkg;

  // Table geometry
  localparam int unsigned MaxBuckets = 1024;
  localparam int unsigned IdxW       = $clog2(MaxBuckets);
  localparam int unsigned CntW       = $clog2(MaxBuckets + 1);

  // Field and sum widths
  localparam int unsigned ValueW  = 24;
  localparam int unsigned SumW    = 34;
  localparam int unsigned BucketW = 11;

  // Stream packing
  localparam int unsigned InDataW  = ((ValueW + 7) / 8) * 8;
  localparam int unsigned OutDataW = ((BucketW + 7) / 8) * 8;

  // Command queue between front and back
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrW      = $clog2(QueueDepth);
  localparam int unsigned QCntW      = $clog2(QueueDepth + 1);

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  typedef struct packed {
    op_e               kind;
    logic [ValueW-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic [BucketW-1:0] bucket_number;
    logic               found;
  } res_t;

endpackage

`default_nettype wire

[hdl/psbl_ram.sv]
`default_nettype none

module psbl_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

[hdl/psbl_front.sv]
`default_nettype none

// Input side: takes items, tags each as load or query, and buffers them
// in a small FIFO so the search engine can stall without blocking input.
module psbl_front (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic                         in_op_i,
  input  wire logic [psbl_pkg::ValueW-1:0]  in_value_i,
  output logic                              cmd_valid_o,
  input  wire logic                         cmd_ready_i,
  output psbl_pkg::cmd_t                    cmd_o
);

  psbl_pkg::cmd_t                   slot_q [psbl_pkg::QueueDepth];
  logic [psbl_pkg::QPtrW-1:0]       wr_ptr_q, wr_ptr_d;
  logic [psbl_pkg::QPtrW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [psbl_pkg::QCntW-1:0]       cnt_q, cnt_d;
  logic                             push, pop;
  psbl_pkg::cmd_t                   cmd_in;

  always_comb begin
    cmd_in.kind  = psbl_pkg::op_e'(in_op_i);
    cmd_in.value = in_value_i;
  end

  assign in_ready_o  = (cnt_q != psbl_pkg::QCntW'(psbl_pkg::QueueDepth));
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = slot_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_valid_o && cmd_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == psbl_pkg::QPtrW'(psbl_pkg::QueueDepth - 1)) ? '0
               : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == psbl_pkg::QPtrW'(psbl_pkg::QueueDepth - 1)) ? '0
               : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

`default_nettype wire

[hdl/psbl_back.sv]
`default_nettype none

// Execution side: appends prefix ends on loads, binary-searches them on
// queries, and holds each result in an output register.
module psbl_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cmd_valid_i,
  output logic                 cmd_ready_o,
  input  wire psbl_pkg::cmd_t  cmd_i,
  output logic                 res_valid_o,
  input  wire logic            res_ready_i,
  output psbl_pkg::res_t       res_o
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SEARCH = 3'b010,
    S_DONE   = 3'b100
  } state_e;

  state_e                            state_q, state_d;
  logic [psbl_pkg::CntW-1:0]         count_q, count_d;
  logic [psbl_pkg::SumW-1:0]         total_q, total_d;
  logic [psbl_pkg::IdxW-1:0]         lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  logic [psbl_pkg::SumW-1:0]         label_q, label_d;
  logic                              hit_q, hit_d;
  logic                              out_valid_q, out_valid_d;
  psbl_pkg::res_t                    out_q, out_d;

  logic                              ram_we;
  logic [psbl_pkg::IdxW-1:0]         ram_raddr;
  logic [psbl_pkg::SumW-1:0]         ram_rdata;
  logic [psbl_pkg::SumW-1:0]         load_sum;
  logic [psbl_pkg::SumW-1:0]         cmd_label;
  logic [psbl_pkg::IdxW-1:0]         last_idx;
  logic [psbl_pkg::IdxW-1:0]         lo_n, hi_n;
  logic [psbl_pkg::IdxW:0]           mid_sum;
  logic                              ge;
  logic                              out_free;
  logic                              not_full;

  assign cmd_ready_o = (state_q == S_IDLE);
  assign out_free    = !out_valid_q || res_ready_i;
  assign not_full    = (count_q != psbl_pkg::CntW'(psbl_pkg::MaxBuckets));
  assign cmd_label   = psbl_pkg::SumW'(cmd_i.value);
  assign load_sum    = total_q + cmd_label;
  assign last_idx    = psbl_pkg::IdxW'(count_q - 1'b1);
  assign ram_we      = cmd_valid_i && cmd_ready_o && (cmd_i.kind == psbl_pkg::OP_LOAD)
                       && not_full;

  // One search step: compare the entry read last cycle, narrow the range
  // and issue the next midpoint in the same cycle.
  assign ge      = (ram_rdata >= label_q);
  assign lo_n    = ge ? lo_q : mid_q + 1'b1;
  assign hi_n    = ge ? mid_q : hi_q;
  assign mid_sum = {1'b0, lo_n} + {1'b0, hi_n};

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    total_d     = total_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    label_d     = label_q;
    hit_d       = hit_q;
    out_valid_d = out_valid_q && !res_ready_i;
    out_d       = out_q;
    ram_raddr   = mid_q;

    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          if (cmd_i.kind == psbl_pkg::OP_LOAD) begin
            if (not_full) begin
              total_d = load_sum;
              count_d = count_q + 1'b1;
            end
          end else begin
            label_d = cmd_label;
            lo_d    = '0;
            hi_d    = last_idx;
            if (cmd_label == '0 || cmd_label > total_q || count_q == '0) begin
              hit_d   = 1'b0;
              state_d = S_DONE;
            end else if (last_idx == '0) begin
              hit_d   = 1'b1;
              state_d = S_DONE;
            end else begin
              hit_d     = 1'b1;
              mid_d     = psbl_pkg::IdxW'({1'b0, last_idx} >> 1);
              ram_raddr = mid_d;
              state_d   = S_SEARCH;
            end
          end
        end
      end
      S_SEARCH: begin
        lo_d      = lo_n;
        hi_d      = hi_n;
        mid_d     = mid_sum[psbl_pkg::IdxW:1];
        ram_raddr = mid_d;
        if (lo_n >= hi_n) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d         = 1'b1;
          out_d.found         = hit_q;
          out_d.bucket_number = hit_q ? psbl_pkg::BucketW'({1'b0, lo_q} + 1'b1) : '0;
          state_d             = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    mid_q   <= mid_d;
    label_q <= label_d;
    hit_q   <= hit_d;
    out_q   <= out_d;
  end

  psbl_ram #(
    .Width (psbl_pkg::SumW),
    .Depth (psbl_pkg::MaxBuckets)
  ) u_prefix_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[psbl_pkg::IdxW-1:0]),
    .wdata_i (load_sum),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

  // Search range stays open while stepping
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SEARCH) |-> (lo_q < hi_q))
    else $error("search range collapsed inside search state");

  // Bucket count never passes the table depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= psbl_pkg::CntW'(psbl_pkg::MaxBuckets))
    else $error("bucket count overflow");

  // A hit names a loaded bucket; a miss names none
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.found ? (out_q.bucket_number != '0 &&
                     out_q.bucket_number <= psbl_pkg::BucketW'(count_q))
                                 : (out_q.bucket_number == '0)))
    else $error("result inconsistent with table");

  // Commands leave the queue only while idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !cmd_ready_o)
    else $error("command taken while busy");

endmodule

`default_nettype wire

[hdl/prefix_sum_bucket_lookup_core.sv]
`default_nettype none

// Prefix-sum bucket lookup.
// Input stream (s_axis): tuser selects the item kind (0 = load, 1 = query),
// tdata[23:0] carries a bucket size or a query label. A load appends one
// bucket and gives no result; loads past 1024 buckets are dropped. A query
// gives one result on m_axis: tdata[10:0] = 1-based bucket holding the
// label (0 if none), tuser = found.
// A load is taken in the idle state and the engine stays idle. A query
// that misses, or finds a table of one bucket, goes from idle straight
// to the done state; otherwise it binary-searches the prefix ends in the
// search state, one read of the prefix-end RAM per binary-search step.
// A 2-item queue sits in front of the engine and a result register behind
// it, so input is taken while the engine searches or while a result waits.
// When m_axis stalls, the finished result is held, the engine waits in its
// done state and the queue fills; s_axis_tready drops once it is full.
// Reset empties the table (count and running total cleared) and drops
// queued items and any pending result. RAM contents are not cleared; only
// entries below the bucket count are ever read.
module prefix_sum_bucket_lookup_core (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [psbl_pkg::InDataW-1:0]    s_axis_tdata,   // [23:0] value
  input  wire logic                            s_axis_tuser,   // [0] operation
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  output logic      [psbl_pkg::OutDataW-1:0]   m_axis_tdata,   // [10:0] bucket_number
  output logic                                 m_axis_tuser    // [0] found
);

  logic            cmd_valid, cmd_ready;
  psbl_pkg::cmd_t  cmd;
  psbl_pkg::res_t  res;

  psbl_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_op_i     (s_axis_tuser),
    .in_value_i  (s_axis_tdata[psbl_pkg::ValueW-1:0]),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  psbl_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  // Pad bits above the bucket number are zero
  assign m_axis_tdata = psbl_pkg::OutDataW'(res.bucket_number);
  assign m_axis_tuser = res.found;

endmodule

`default_nettype wire
